@@ hw/rtl/lpr_pkg.sv @@
// lpr_pkg: shared types, status codes and helpers for the longest prefix router
// used by lpr_cell and ipv4_longest_prefix_router_core; no dependencies
package lpr_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int TABLE_DEPTH_MAX = 1024;
	localparam int SLOT_W = $clog2(TABLE_DEPTH_MAX);
	localparam int PORT_COUNT = 16;

	localparam logic [2:0] ST_FORWARDED = 3'd0;
	localparam logic [2:0] ST_NO_ROUTE = 3'd1;
	localparam logic [2:0] ST_TTL_EXPIRED = 3'd2;
	localparam logic [2:0] ST_STORED = 3'd3;
	localparam logic [2:0] ST_FULL = 3'd4;

	localparam logic KIND_ADD = 1'b0;
	localparam logic KIND_ROUTE = 1'b1;

	localparam logic [5:0] MAX_LEN = 6'd32;

	// running search state handed from cell to cell
	typedef struct packed {
		logic active;
		logic found_same;
		logic [SLOT_W-1:0] same_slot;
		logic found_free;
		logic [SLOT_W-1:0] free_slot;
		logic best_valid;
		logic [5:0] best_len;
		logic [3:0] best_port;
		logic best_has_hop;
		logic [31:0] best_hop;
	} acc_t;

	// table write broadcast to every cell
	typedef struct packed {
		logic en;
		logic [SLOT_W-1:0] slot;
		logic [31:0] prefix;
		logic [5:0] len;
		logic has_hop;
		logic [31:0] hop;
		logic [3:0] port;
	} wr_t;

	function automatic logic [31:0] prefix_mask(input logic [5:0] len);
		logic [31:0] m;
		if (len == 6'd0) begin
			m = 32'h0;
		end else if (len >= MAX_LEN) begin
			m = 32'hFFFF_FFFF;
		end else begin
			m = 32'hFFFF_FFFF << (MAX_LEN - len);
		end
		return m;
	endfunction

endpackage

@@ hw/rtl/lpr_cell.sv @@
// lpr_cell: one routing table entry plus one register stage of the search chain
// depends on lpr_pkg
module lpr_cell #(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [31:0]       item_prefix,
	input  logic [31:0]       item_dest,
	input  lpr_pkg::acc_t     acc_in,
	input  lpr_pkg::wr_t      wr,
	output lpr_pkg::acc_t     acc_out
);

	localparam logic [lpr_pkg::SLOT_W-1:0] MY_SLOT = IDX[lpr_pkg::SLOT_W-1:0];

	logic        valid_q;
	logic [31:0] prefix_q;
	logic [5:0]  len_q;
	logic        has_hop_q;
	logic [31:0] hop_q;
	logic [3:0]  port_q;
	lpr_pkg::acc_t acc_q;
	lpr_pkg::acc_t acc_next;

	logic same_hit;
	logic route_hit;

	assign same_hit = valid_q && (prefix_q == item_prefix);
	assign route_hit = valid_q &&
		(((prefix_q ^ item_dest) & lpr_pkg::prefix_mask(len_q)) == 32'h0) &&
		(!acc_in.best_valid || (len_q >= acc_in.best_len));

	always_comb begin
		acc_next = acc_in;
		if (!acc_in.found_same && same_hit) begin
			acc_next.found_same = 1'b1;
			acc_next.same_slot = MY_SLOT;
		end
		if (!acc_in.found_free && !valid_q) begin
			acc_next.found_free = 1'b1;
			acc_next.free_slot = MY_SLOT;
		end
		// later slots win ties, so equal length replaces the earlier pick
		if (route_hit) begin
			acc_next.best_valid = 1'b1;
			acc_next.best_len = len_q;
			acc_next.best_port = port_q;
			acc_next.best_has_hop = has_hop_q;
			acc_next.best_hop = hop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			acc_q <= '0;
		end else begin
			acc_q <= acc_next;
			if (wr.en && (wr.slot == MY_SLOT)) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && (wr.slot == MY_SLOT)) begin
			prefix_q <= wr.prefix;
			len_q <= wr.len;
			has_hop_q <= wr.has_hop;
			hop_q <= wr.hop;
			port_q <= wr.port;
		end
	end

	assign acc_out = acc_q;

endmodule

@@ hw/rtl/ipv4_longest_prefix_router_core.sv @@
// ipv4_longest_prefix_router_core: one beat in, one result beat out per item.
// the search walks the chain of table cells one cell per cycle, one item at
// a time, so a new item is taken only once the last result has moved into
// the output register, and a result waiting on out_ready holds the finished
// search until the output register frees up.
// reset: arst_n clears every table valid bit and the control state at once.
module ipv4_longest_prefix_router_core #(
	parameter int TABLE_DEPTH = lpr_pkg::TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [31:0] prefix,
	input  logic [5:0]  prefix_bits,
	input  logic        hop_present,
	input  logic [31:0] hop_address,
	input  logic [3:0]  out_port,
	input  logic [31:0] dest_address,
	input  logic [7:0]  hops_left,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [3:0]  send_port,
	output logic [31:0] send_to,
	output logic [7:0]  new_ttl
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LAUNCH = 2'd1;
	localparam logic [1:0] ST_WALK = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;

	logic        kind_q;
	logic [31:0] prefix_q;
	logic [5:0]  len_q;
	logic        has_hop_q;
	logic [31:0] hop_q;
	logic [3:0]  port_q;
	logic [31:0] dest_q;
	logic [7:0]  ttl_q;

	logic [2:0]  res_status_q;
	logic [3:0]  res_port_q;
	logic [31:0] res_to_q;
	logic [7:0]  res_ttl_q;

	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [3:0]  send_port_q;
	logic [31:0] send_to_q;
	logic [7:0]  new_ttl_q;

	lpr_pkg::acc_t chain [TABLE_DEPTH+1];
	lpr_pkg::acc_t tail;
	lpr_pkg::wr_t  wr;

	logic [5:0] len_sat;
	logic [3:0] port_sat;
	logic in_beat;
	logic out_free;

	logic [2:0]  res_status;
	logic [3:0]  res_port;
	logic [31:0] res_to;
	logic [7:0]  res_ttl;

	assign in_ready = (state_q == ST_IDLE);
	assign in_beat = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign len_sat = (prefix_bits > lpr_pkg::MAX_LEN) ? lpr_pkg::MAX_LEN : prefix_bits;
	assign port_sat = (32'(out_port) > 32'(lpr_pkg::PORT_COUNT - 1)) ?
		4'(lpr_pkg::PORT_COUNT - 1) : out_port;

	always_comb begin
		chain[0] = '0;
		chain[0].active = (state_q == ST_LAUNCH);
	end

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		lpr_cell #(
			.IDX(i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.item_prefix(prefix_q),
			.item_dest  (dest_q),
			.acc_in     (chain[i]),
			.wr         (wr),
			.acc_out    (chain[i+1])
		);
	end

	assign tail = chain[TABLE_DEPTH];

	always_comb begin
		wr.en = tail.active && (kind_q == lpr_pkg::KIND_ADD) &&
			(tail.found_same || tail.found_free);
		wr.slot = tail.found_same ? tail.same_slot : tail.free_slot;
		wr.prefix = prefix_q;
		wr.len = len_q;
		wr.has_hop = has_hop_q;
		wr.hop = hop_q;
		wr.port = port_q;
	end

	always_comb begin
		res_status = lpr_pkg::ST_NO_ROUTE;
		res_port = 4'd0;
		res_to = 32'd0;
		res_ttl = 8'd0;
		if (kind_q == lpr_pkg::KIND_ADD) begin
			res_status = (tail.found_same || tail.found_free) ?
				lpr_pkg::ST_STORED : lpr_pkg::ST_FULL;
		end else if (!tail.best_valid) begin
			res_status = lpr_pkg::ST_NO_ROUTE;
		end else if (ttl_q <= 8'd1) begin
			res_status = lpr_pkg::ST_TTL_EXPIRED;
		end else begin
			res_status = lpr_pkg::ST_FORWARDED;
			res_port = tail.best_port;
			res_to = tail.best_has_hop ? tail.best_hop : dest_q;
			res_ttl = ttl_q - 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						state_q <= ST_LAUNCH;
					end
				end
				ST_LAUNCH: begin
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (tail.active) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			kind_q <= kind;
			prefix_q <= prefix;
			len_q <= len_sat;
			has_hop_q <= hop_present;
			hop_q <= hop_address;
			port_q <= port_sat;
			dest_q <= dest_address;
			ttl_q <= hops_left;
		end
		if (tail.active) begin
			res_status_q <= res_status;
			res_port_q <= res_port;
			res_to_q <= res_to;
			res_ttl_q <= res_ttl;
		end
		if ((state_q == ST_DONE) && out_free) begin
			status_q <= res_status_q;
			send_port_q <= res_port_q;
			send_to_q <= res_to_q;
			new_ttl_q <= res_ttl_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign send_port = send_port_q;
	assign send_to = send_to_q;
	assign new_ttl = new_ttl_q;

`ifndef SYNTH
	a_tail_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		tail.active |-> (state_q == ST_WALK))
		else $error("search beat left the chain outside the walk");

	a_wr_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (32'(wr.slot) < TABLE_DEPTH))
		else $error("table write to a slot beyond the table");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result beat raised without a finished search");
`endif

endmodule
